// File: hdl/ctcgd_pkg.sv
`timescale 1ns / 1ps

package ctcgd_pkg;

    localparam int SCORE_W   = 16;
    localparam int IDX_W     = 15;
    localparam int TOTAL_W   = 23;
    localparam int COUNT_W   = 7;
    localparam int DICT_W    = 16;
    localparam int MAX_VOCAB = 32768;
    localparam int MAX_STEPS = 64;

    // one quotient bit per cycle over the magnitude of the total
    localparam int DIV_STEPS = TOTAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] ADDR_DICT_SIZE = CFG_ADDR_W'(0);
    localparam logic [DICT_W-1:0]     DICT_SIZE_RESET = DICT_W'(MAX_VOCAB);

    localparam int OUT_DATA_W = 48;

    typedef enum logic [1:0] {
        S_RUN,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic div_finish;
    } cmd_t;

endpackage

// File: hdl/ctcgd_ctrl.sv
`timescale 1ns / 1ps

module ctcgd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              step_end,
    input  logic              seq_end,
    input  logic              m_tready,
    output logic              s_tready,
    output logic              m_tvalid,
    output ctcgd_pkg::cmd_t   cmd
);
    import ctcgd_pkg::*;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_RUN:
            begin
                if (s_tvalid && slot_free && step_end && seq_end)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_RUN;
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_comb
    begin
        s_tready       = 1'b0;
        cmd            = '0;
        cnt_next       = '0;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            S_RUN:
            begin
                s_tready   = slot_free;
                cmd.accept = s_tvalid && slot_free;
                // a plain step end goes straight to the output register
                if (cmd.accept && step_end && !seq_end)
                begin
                    out_valid_next = 1'b1;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            S_FIN:
            begin
                cmd.div_finish = 1'b1;
                out_valid_next = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/ctcgd_dp.sv
`timescale 1ns / 1ps

module ctcgd_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  ctcgd_pkg::cmd_t                        cmd,
    input  logic signed [ctcgd_pkg::SCORE_W-1:0]   score,
    input  logic                                   step_end,
    input  logic                                   seq_end,
    input  logic [ctcgd_pkg::DICT_W-1:0]           dict_size,
    output logic                                   char_valid,
    output logic [ctcgd_pkg::IDX_W-1:0]            char_index,
    output logic signed [ctcgd_pkg::SCORE_W-1:0]   char_score,
    output logic                                   sequence_done,
    output logic signed [ctcgd_pkg::SCORE_W-1:0]   mean_score
);
    import ctcgd_pkg::*;

    // step and sequence state
    logic [IDX_W-1:0]          pos_reg;
    logic signed [SCORE_W-1:0] best_score_reg;
    logic [IDX_W-1:0]          best_index_reg;
    logic [IDX_W-1:0]          prev_winner_reg;
    logic                      prev_valid_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [COUNT_W-1:0]        count_reg;

    // result and divider
    logic                      char_valid_reg;
    logic [IDX_W-1:0]          char_index_reg;
    logic signed [SCORE_W-1:0] char_score_reg;
    logic                      seq_done_reg;
    logic signed [SCORE_W-1:0] mean_reg;
    logic [COUNT_W-1:0]        rem_reg;
    logic [TOTAL_W-1:0]        quo_reg;
    logic [COUNT_W-1:0]        divisor_reg;
    logic                      div_neg_reg;
    logic                      div_zero_reg;

    logic                      take;
    logic signed [SCORE_W-1:0] cand_score;
    logic [IDX_W-1:0]          cand_index;
    logic                      emit;
    logic                      add;
    logic signed [TOTAL_W-1:0] total_sum;
    logic [COUNT_W-1:0]        count_sum;
    logic [TOTAL_W-1:0]        total_mag;
    logic [COUNT_W:0]          trial;
    logic                      trial_ge;
    logic [COUNT_W-1:0]        rem_step;
    logic [SCORE_W-1:0]        quo_low;
    logic signed [SCORE_W-1:0] mean_val;

    always_comb
    begin
        take       = (pos_reg == '0) || (score > best_score_reg);
        cand_score = take ? score : best_score_reg;
        cand_index = take ? pos_reg : best_index_reg;
        emit = (!prev_valid_reg || (cand_index != prev_winner_reg))
               && (cand_index != '0)
               && ({1'b0, cand_index} < dict_size);
        // characters beyond the count limit are reported but not averaged
        add       = emit && (count_reg < COUNT_W'(MAX_STEPS));
        total_sum = add ? total_reg + TOTAL_W'(cand_score) : total_reg;
        count_sum = add ? count_reg + 1'b1 : count_reg;
        total_mag = total_sum[TOTAL_W-1] ? TOTAL_W'(-total_sum) : TOTAL_W'(total_sum);

        trial    = {rem_reg, quo_reg[TOTAL_W-1]};
        trial_ge = trial >= {1'b0, divisor_reg};
        rem_step = trial_ge ? COUNT_W'(trial - {1'b0, divisor_reg}) : COUNT_W'(trial);

        quo_low  = quo_reg[SCORE_W-1:0];
        mean_val = div_zero_reg ? '0 : (div_neg_reg ? SCORE_W'(-quo_low) : quo_low);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            best_score_reg  <= '0;
            best_index_reg  <= '0;
            prev_winner_reg <= '0;
            prev_valid_reg  <= 1'b0;
            total_reg       <= '0;
            count_reg       <= '0;
        end
        else if (cmd.accept)
        begin
            if (!step_end)
            begin
                best_score_reg <= cand_score;
                best_index_reg <= cand_index;
                // saturate: later scores compete as the last class
                if (pos_reg != IDX_W'(MAX_VOCAB - 1))
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            else
            begin
                pos_reg        <= '0;
                best_score_reg <= '0;
                best_index_reg <= '0;
                if (seq_end)
                begin
                    prev_winner_reg <= '0;
                    prev_valid_reg  <= 1'b0;
                    total_reg       <= '0;
                    count_reg       <= '0;
                end
                else
                begin
                    prev_winner_reg <= cand_index;
                    prev_valid_reg  <= 1'b1;
                    total_reg       <= total_sum;
                    count_reg       <= count_sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && step_end)
        begin
            char_valid_reg <= emit;
            char_index_reg <= emit ? cand_index : '0;
            char_score_reg <= cand_score;
            seq_done_reg   <= seq_end;
            mean_reg       <= '0;
            rem_reg        <= '0;
            quo_reg        <= total_mag;
            divisor_reg    <= count_sum;
            div_neg_reg    <= total_sum[TOTAL_W-1];
            div_zero_reg   <= (count_sum == '0);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[TOTAL_W-2:0], trial_ge};
        end
        else if (cmd.div_finish)
        begin
            mean_reg <= mean_val;
        end
    end

    assign char_valid    = char_valid_reg;
    assign char_index    = char_index_reg;
    assign char_score    = char_score_reg;
    assign sequence_done = seq_done_reg;
    assign mean_score    = mean_reg;

endmodule

// File: hdl/ctc_greedy_decoder_top.sv
`timescale 1ns / 1ps

// CTC greedy decoder. Class scores (signed Q8.8) enter on the slave stream one per
// cycle in vocabulary order while s_tready is high; s_tlast marks the last score of
// a time step and s_tuser, valid with s_tlast, the last step of a sequence. Each
// step end gives one result beat on the master stream, a plain step end the cycle
// after its last score and a sequence end once the mean is ready: m_tuser says a
// character was emitted, m_tlast closes the sequence and then carries the mean of
// the emitted scores. Input is held off while a serial divider makes one quotient
// bit per cycle over the 23-bit total and a final step signs the mean. Write
// register dict_size (byte address 0) only while the stream is idle; not enforced.
module ctc_greedy_decoder_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [ctcgd_pkg::SCORE_W-1:0]         s_tdata,  // [15:0] score
    input  logic                                  s_tlast,  // step_end
    input  logic                                  s_tuser,  // sequence_end
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [14:0] char_index, [30:15] char_score, [46:31] mean_score, [47] zero
    output logic [ctcgd_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                  m_tlast,  // sequence_done
    output logic                                  m_tuser,  // char_valid
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ctcgd_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [ctcgd_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [ctcgd_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready
);
    import ctcgd_pkg::*;

    logic [DICT_W-1:0]         dict_size_reg;
    cmd_t                      cmd;
    logic [IDX_W-1:0]          char_index;
    logic signed [SCORE_W-1:0] char_score;
    logic signed [SCORE_W-1:0] mean_score;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DICT_SIZE) ? CFG_DATA_W'(dict_size_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dict_size_reg <= DICT_SIZE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_DICT_SIZE))
        begin
            dict_size_reg <= pwdata[DICT_W-1:0];
        end
    end

    ctcgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .step_end (s_tlast),
        .seq_end  (s_tuser),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    ctcgd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .score         (s_tdata),
        .step_end      (s_tlast),
        .seq_end       (s_tuser),
        .dict_size     (dict_size_reg),
        .char_valid    (m_tuser),
        .char_index    (char_index),
        .char_score    (char_score),
        .sequence_done (m_tlast),
        .mean_score    (mean_score)
    );

    assign m_tdata = {1'b0, mean_score, char_score, char_index};

    a_ready_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input taken while a result is still held");

    a_emit_not_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[14:0] != '0))
        else $error("blank class emitted as a character");

    a_mean_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[46:31] == '0))
        else $error("mean reported before sequence end");

    a_seq_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast && s_tuser) |=> !s_tready)
        else $error("input not held off during the mean division");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import ctcgd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int QUIET_LIMIT     = 4000;
    localparam int RANDOM_SCORES   = 750;
    localparam int MAX_PRINTED     = 50;

    typedef struct packed {
        logic                ch_valid;
        logic [IDX_W-1:0]    ch_index;
        logic [SCORE_W-1:0]  ch_score;
        logic                seq_done;
        logic [SCORE_W-1:0]  mean;
    } char_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SCORE_W-1:0]     s_tdata;   // [15:0] score
    logic                   s_tlast;   // step_end
    logic                   s_tuser;   // sequence_end
    logic                   m_tvalid;
    logic                   m_tready;
    // [14:0] char_index, [30:15] char_score, [46:31] mean_score, [47] zero
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tlast;   // sequence_done
    logic                   m_tuser;   // char_valid
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [CFG_ADDR_W-1:0]  paddr;
    logic [CFG_DATA_W-1:0]  pwdata;
    logic [CFG_DATA_W-1:0]  prdata;
    logic                   pready;

    // decoder state as predicted
    logic [IDX_W-1:0]         vocab_pos;
    logic signed [SCORE_W-1:0] step_best;
    logic [IDX_W-1:0]         step_best_idx;
    logic [IDX_W-1:0]         last_winner;
    logic                     last_winner_ok;
    logic signed [TOTAL_W-1:0] emitted_total;
    logic [COUNT_W-1:0]       emitted_count;
    logic [DICT_W-1:0]        dict_limit;

    char_result_t expected_chars[$];
    int           mismatches;
    int           scores_sent;
    int           quiet_cycles;
    bit           idle_on;
    bit           hold_off_req;

    ctc_greedy_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic void clear_decoder();
        vocab_pos      = '0;
        step_best      = '0;
        step_best_idx  = '0;
        last_winner    = '0;
        last_winner_ok = 1'b0;
        emitted_total  = '0;
        emitted_count  = '0;
        dict_limit     = DICT_SIZE_RESET;
    endfunction

    // running arg-max per step, character emission and mean per sequence
    function automatic void decode_score(input logic [SCORE_W-1:0] raw, input logic step_end,
                                         input logic seq_end);
        logic signed [SCORE_W-1:0] sc;
        logic [IDX_W-1:0]          win;
        logic                      emit;
        int                        t;
        int                        c;
        int                        mean;
        char_result_t              r;
        sc = raw;
        if (vocab_pos == '0 || sc > step_best)
        begin
            step_best     = sc;
            step_best_idx = vocab_pos;
        end
        // saturate on the last class
        if (vocab_pos != IDX_W'(MAX_VOCAB - 1))
            vocab_pos = vocab_pos + 1'b1;
        if (!step_end)
            return;
        win  = step_best_idx;
        emit = (!last_winner_ok || win != last_winner) && win != '0 &&
               {1'b0, win} < dict_limit;
        if (emit && emitted_count < MAX_STEPS)
        begin
            emitted_total = emitted_total + step_best;
            emitted_count = emitted_count + 1'b1;
        end
        r.ch_valid = emit;
        r.ch_index = emit ? win : '0;
        r.ch_score = step_best;
        r.seq_done = seq_end;
        r.mean     = '0;
        last_winner    = win;
        last_winner_ok = 1'b1;
        vocab_pos      = '0;
        step_best      = '0;
        step_best_idx  = '0;
        if (seq_end)
        begin
            t    = emitted_total;
            c    = emitted_count;
            mean = (c != 0) ? t / c : 0;
            r.mean = mean[SCORE_W-1:0];
            last_winner    = '0;
            last_winner_ok = 1'b0;
            emitted_total  = '0;
            emitted_count  = '0;
        end
        expected_chars.insert(expected_chars.size(), r);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SCORE_W-1:0] rand_score(input int mode);
        int pick;
        case (mode)
            0: return SCORE_W'($urandom);
            1: return SCORE_W'($urandom_range(0, 6) - 3);
            default:
            begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    // offer one score beat and wait until it is taken
    task automatic push_score(input logic [SCORE_W-1:0] sc, input logic step_end,
                              input logic seq_end);
        int n;
        n = gap_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        s_tlast  <= step_end;
        s_tuser  <= seq_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_score(sc, step_end, seq_end);
        scores_sent++;
    endtask

    task automatic send_step(input int len, input bit seq_last);
        int k;
        int mode;
        mode = $urandom_range(0, 2);
        for (k = 0; k < len; k++)
        begin
            if (k == len - 1)
                push_score(rand_score(mode), 1'b1, seq_last);
            else
                push_score(rand_score(mode), 1'b0, $urandom_range(0, 7) == 0);
        end
    endtask

    // one step whose winner sits at a chosen position
    task automatic send_step_won(input int len, input int win, input logic signed [15:0] top,
                                 input bit seq_last);
        int k;
        logic signed [15:0] other;
        for (k = 0; k < len; k++)
        begin
            // negative filler below the winner
            other = SCORE_W'($urandom_range(0, 32767) + 32768);
            if (other >= top)
                other = SCORE_W'(top - 1);
            push_score((k == win) ? top : other, k == len - 1, seq_last && k == len - 1);
        end
    endtask

    // hold the input until every result has come out, then let the divider settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_dict(input logic [DICT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DICT_SIZE;
        pwdata  <= CFG_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        dict_limit = v;
    endtask

    task automatic check_dict();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_DICT_SIZE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[DICT_W-1:0] !== dict_limit)
            flag_mismatch($sformatf("dict_size read %0d, want %0d",
                                    prdata[DICT_W-1:0], dict_limit));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic test_directed_cases();
        // ties: the first maximum wins
        push_score(16'h8000, 1'b0, 1'b0);
        push_score(-16'sd7,  1'b0, 1'b0);
        push_score(-16'sd7,  1'b0, 1'b0);
        push_score(-16'sd9,  1'b1, 1'b0);
        // same winner again: suppressed
        push_score(16'd0, 1'b0, 1'b0);
        push_score(16'd7, 1'b0, 1'b0);
        push_score(16'd7, 1'b1, 1'b0);
        // blank wins; sequence_end without step_end is ignored
        push_score(16'h7FFF, 1'b0, 1'b1);
        push_score(16'd3,    1'b0, 1'b1);
        push_score(16'd3,    1'b1, 1'b0);
        // repeat after a blank: emitted
        push_score(-16'sd5,  1'b0, 1'b0);
        push_score(-16'sd3,  1'b0, 1'b0);
        push_score(16'h8000, 1'b1, 1'b0);
        // negative mean truncates toward zero
        push_score(16'h8000, 1'b0, 1'b0);
        push_score(16'h8000, 1'b0, 1'b0);
        push_score(16'h8000, 1'b0, 1'b0);
        push_score(-16'sd1,  1'b1, 1'b1);
        // sequence with no character
        push_score(16'd5, 1'b1, 1'b1);
        // top score as the only character
        push_score(16'd0,    1'b0, 1'b0);
        push_score(16'h7FFF, 1'b1, 1'b1);
    endtask

    task automatic test_dictionary_limit();
        drain_results();
        write_dict(16'd5);
        check_dict();
        send_step_won(6, 4, 16'sd900, 1'b0);
        send_step_won(7, 5, 16'sd800, 1'b1);
        drain_results();
        write_dict(16'd1);
        check_dict();
        send_step_won(3, 1, 16'sd50, 1'b0);
        send_step_won(3, 2, 16'sd60, 1'b1);
        drain_results();
        write_dict(16'd0);
        check_dict();
        send_step_won(3, 2, 16'sd70, 1'b1);
        drain_results();
        write_dict(DICT_SIZE_RESET);
        check_dict();
    endtask

    // more characters than the count limit of the mean takes
    task automatic test_char_overflow();
        int k;
        for (k = 0; k < MAX_STEPS + 6; k++)
            send_step_won(3, 1 + (k % 2), 16'sd30000 + 16'($urandom_range(0, 2767)),
                          k == MAX_STEPS + 5);
    endtask

    task automatic test_backpressure();
        int k;
        idle_on = 1'b0;
        hold_off_req = 1'b1;
        for (k = 0; k < 60; k++)
            send_step($urandom_range(1, 2), k % 7 == 6);
        send_step(1, 1'b1);
        // pause the sender until the output has caught up
        drain_results();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sequences();
        int start;
        int nseq;
        int nsteps;
        int len;
        int s;
        int q;
        int r;
        logic [DICT_W-1:0] dsz;
        start = scores_sent;
        while (scores_sent - start < RANDOM_SCORES)
        begin
            drain_results();
            case ($urandom_range(0, 7))
                0: dsz = '0;
                1: dsz = 16'd1;
                2: dsz = 16'd2;
                3: dsz = DICT_W'($urandom_range(3, 8));
                4: dsz = DICT_W'($urandom_range(9, 40));
                5: dsz = 16'd32767;
                6: dsz = DICT_SIZE_RESET;
                default: dsz = DICT_W'($urandom);
            endcase
            write_dict(dsz);
            check_dict();
            idle_on = ($urandom_range(0, 3) != 0);
            nseq = $urandom_range(2, 5);
            for (q = 0; q < nseq; q++)
            begin
                nsteps = ($urandom_range(0, 19) == 0) ? $urandom_range(65, 70)
                                                      : $urandom_range(1, 8);
                for (s = 0; s < nsteps; s++)
                begin
                    r = $urandom_range(0, 99);
                    if (nsteps > 60)
                        len = $urandom_range(1, 3);
                    else if (r < 75)
                        len = $urandom_range(1, 6);
                    else if (r < 95)
                        len = $urandom_range(7, 30);
                    else
                        len = $urandom_range(60, 150);
                    send_step(len, s == nsteps - 1);
                end
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        mismatches   = 0;
        scores_sent  = 0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        clear_decoder();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_dict();
        test_directed_cases();
        test_dictionary_limit();
        test_char_overflow();
        test_backpressure();
        test_random_sequences();
        drain_results();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : result_sink
        int n;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end
            else
            begin
                n = gap_len();
                if (n == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        char_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_chars.size() == 0)
                flag_mismatch("result beat with nothing pending");
            else
            begin
                want = expected_chars.pop_front();
                if (m_tuser !== want.ch_valid)
                    flag_mismatch($sformatf("char_valid %b, want %b", m_tuser, want.ch_valid));
                if (m_tdata[14:0] !== want.ch_index)
                    flag_mismatch($sformatf("char_index %0d, want %0d",
                                            m_tdata[14:0], want.ch_index));
                if (m_tdata[30:15] !== want.ch_score)
                    flag_mismatch($sformatf("char_score %h, want %h",
                                            m_tdata[30:15], want.ch_score));
                if (m_tlast !== want.seq_done)
                    flag_mismatch($sformatf("sequence_done %b, want %b", m_tlast, want.seq_done));
                if (m_tdata[46:31] !== want.mean)
                    flag_mismatch($sformatf("mean_score %h, want %h",
                                            m_tdata[46:31], want.mean));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// File: ctc_greedy_decoder_top.f
hdl/ctcgd_pkg.sv
hdl/ctcgd_ctrl.sv
hdl/ctcgd_dp.sv
hdl/ctc_greedy_decoder_top.sv
test/tb_top.sv
